// ===== src/wpp_pkg.sv =====
package wpp_pkg;

	localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
	localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
	localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
	localparam logic [31:0] TAG_DATA = 32'h6461_7461;

	localparam int unsigned FMT_BYTES   = 16;
	localparam int unsigned FMT_IDX_W   = $clog2(FMT_BYTES);
	localparam int unsigned HDR_BYTES   = 8;
	localparam int unsigned HDR_CNT_W   = $clog2(HDR_BYTES);
	localparam int unsigned RIFF_LEN    = 12;

	localparam logic [17:0] RATE_RESET  = 18'd44100;

	typedef enum logic {
		CFG_FILE_LENGTH   = 1'b0,
		CFG_REQUIRED_RATE = 1'b1
	} cfg_index_t;

	typedef enum logic [2:0] {
		PH_RIFF,
		PH_HDR,
		PH_FMT,
		PH_SKIP,
		PH_DATA,
		PH_STOP
	} phase_t;

	typedef enum logic {
		KIND_FRAME = 1'b0,
		KIND_ERROR = 1'b1
	} kind_t;

	typedef enum logic [2:0] {
		ERR_BAD_RIFF    = 3'd0,
		ERR_PAST_END    = 3'd1,
		ERR_FMT_SHORT   = 3'd2,
		ERR_NO_CHUNK    = 3'd3,
		ERR_UNSUPPORTED = 3'd4,
		ERR_DATA_SIZE   = 3'd5,
		ERR_DATA_FIRST  = 3'd6
	} err_code_t;

	typedef struct packed {
		logic [7:0] byte_value;
		logic       file_start;
	} in_item_t;

	typedef struct packed {
		kind_t            kind;
		logic signed [15:0] sample;
		logic             last;
		err_code_t        code;
	} res_item_t;

	typedef struct packed {
		logic [31:0] file_length;
		logic [17:0] required_rate;
	} cfg_t;

endpackage

// ===== src/wpp_in_queue.sv =====
module wpp_in_queue import wpp_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  in_item_t push_item,
	output logic     full,
	input  logic     pop,
	output logic     valid,
	output in_item_t head
);

	in_item_t    mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign full    = (count_q == 2'd2);
	assign valid   = (count_q != 2'd0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && !full;
	assign do_pop  = pop && valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)
				count_q <= count_q + 2'd1;
			else if (do_pop && !do_push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== src/wpp_parser.sv =====
module wpp_parser import wpp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      in_valid,
	input  in_item_t  in_item,
	output logic      in_pop,
	input  logic      out_room,
	output logic      res_valid,
	output res_item_t res
);

	phase_t                 phase_q, phase_d;
	logic [31:0]            pos_q, pos_d;
	logic [63:0]            shift_q, shift_d;
	logic [HDR_CNT_W-1:0]   hcnt_q, hcnt_d;
	logic [FMT_IDX_W-1:0]   fcnt_q, fcnt_d;
	logic [32:0]            left_q, left_d;
	logic                   seen_q, seen_d;
	logic [7:0]             hold_q, hold_d;
	logic                   hold_v_q, hold_v_d;
	logic [7:0]             fmt_q [FMT_BYTES];

	phase_t      phase_e;
	logic [31:0] pos_e, pos_n;
	logic [63:0] shift_e, shift_n;
	logic        seen_e;
	logic [7:0]  b;
	logic [31:0] id, size;
	logic [32:0] span, left_dec, left_two;
	logic        end_bad, room_bad, fmt_ok;
	logic        emit;

	assign b      = in_item.byte_value;
	assign in_pop = in_valid && out_room;

	assign phase_e = in_item.file_start ? PH_RIFF : phase_q;
	assign pos_e   = in_item.file_start ? 32'd0 : pos_q;
	assign shift_e = in_item.file_start ? 64'd0 : shift_q;
	assign seen_e  = in_item.file_start ? 1'b0 : seen_q;
	assign pos_n   = pos_e + 32'd1;
	assign shift_n = {shift_e[55:0], b};

	assign id       = shift_n[63:32];
	assign size     = {shift_n[7:0], shift_n[15:8], shift_n[23:16], shift_n[31:24]};
	assign span     = {1'b0, size} + {32'd0, size[0]};
	assign end_bad  = ({2'b00, pos_n} + {1'b0, span}) > {2'b00, cfg.file_length};
	assign room_bad = ({1'b0, pos_n} + 33'd8) > {1'b0, cfg.file_length};
	assign left_dec = (left_q != 33'd0) ? left_q - 33'd1 : 33'd0;
	assign left_two = (left_q >= 33'd2) ? left_q - 33'd2 : 33'd0;

	assign fmt_ok = ({fmt_q[1], fmt_q[0]} == 16'd1) &&
			({fmt_q[3], fmt_q[2]} == 16'd1) &&
			({fmt_q[7], fmt_q[6], fmt_q[5], fmt_q[4]} == {14'd0, cfg.required_rate}) &&
			({fmt_q[11], fmt_q[10], fmt_q[9], fmt_q[8]} ==
				{13'd0, cfg.required_rate, 1'b0}) &&
			({fmt_q[13], fmt_q[12]} == 16'd2) &&
			({fmt_q[15], fmt_q[14]} == 16'd16);

	always_comb begin
		phase_d  = phase_q;
		pos_d    = pos_q;
		shift_d  = shift_q;
		hcnt_d   = hcnt_q;
		fcnt_d   = fcnt_q;
		left_d   = left_q;
		seen_d   = seen_q;
		hold_d   = hold_q;
		hold_v_d = hold_v_q;
		emit     = 1'b0;
		res      = '0;
		if (in_pop) begin
			phase_d = phase_e;
			pos_d   = pos_e;
			shift_d = shift_e;
			seen_d  = seen_e;
			unique case (phase_e)
				PH_RIFF: begin
					shift_d = shift_n;
					pos_d   = pos_n;
					if (pos_e == 32'd3 && shift_n[31:0] != TAG_RIFF) begin
						emit     = 1'b1;
						res.code = ERR_BAD_RIFF;
					end else if (pos_e >= 32'd11) begin
						if (shift_n[31:0] != TAG_WAVE ||
								cfg.file_length < 32'(RIFF_LEN)) begin
							emit     = 1'b1;
							res.code = ERR_BAD_RIFF;
						end else begin
							phase_d = PH_HDR;
							hcnt_d  = '0;
							shift_d = '0;
							if (room_bad) begin
								emit     = 1'b1;
								res.code = ERR_NO_CHUNK;
							end
						end
					end
				end
				PH_HDR: begin
					shift_d = shift_n;
					pos_d   = pos_n;
					hcnt_d  = hcnt_q + 1'b1;
					if (hcnt_q == HDR_CNT_W'(HDR_BYTES - 1)) begin
						if (end_bad) begin
							emit     = 1'b1;
							res.code = ERR_PAST_END;
						end else if (id == TAG_FMT) begin
							if (size < 32'(FMT_BYTES)) begin
								emit     = 1'b1;
								res.code = ERR_FMT_SHORT;
							end else begin
								phase_d = PH_FMT;
								left_d  = span;
								fcnt_d  = '0;
							end
						end else if (id == TAG_DATA) begin
							if (!seen_e) begin
								emit     = 1'b1;
								res.code = ERR_DATA_FIRST;
							end else if (!fmt_ok) begin
								emit     = 1'b1;
								res.code = ERR_UNSUPPORTED;
							end else if (size == 32'd0 || size[0]) begin
								emit     = 1'b1;
								res.code = ERR_DATA_SIZE;
							end else begin
								phase_d  = PH_DATA;
								left_d   = {1'b0, size};
								hold_v_d = 1'b0;
							end
						end else if (span == 33'd0) begin
							hcnt_d  = '0;
							shift_d = '0;
							if (room_bad) begin
								emit     = 1'b1;
								res.code = ERR_NO_CHUNK;
							end
						end else begin
							phase_d = PH_SKIP;
							left_d  = span;
						end
					end
				end
				PH_FMT: begin
					pos_d  = pos_n;
					fcnt_d = fcnt_q + 1'b1;
					left_d = left_dec;
					if (fcnt_q == FMT_IDX_W'(FMT_BYTES - 1)) begin
						seen_d = 1'b1;
						if (left_dec == 33'd0) begin
							phase_d = PH_HDR;
							hcnt_d  = '0;
							shift_d = '0;
							if (room_bad) begin
								emit     = 1'b1;
								res.code = ERR_NO_CHUNK;
							end
						end else begin
							phase_d = PH_SKIP;
						end
					end
				end
				PH_SKIP: begin
					pos_d  = pos_n;
					left_d = left_dec;
					if (left_dec == 33'd0) begin
						phase_d = PH_HDR;
						hcnt_d  = '0;
						shift_d = '0;
						if (room_bad) begin
							emit     = 1'b1;
							res.code = ERR_NO_CHUNK;
						end
					end
				end
				PH_DATA: begin
					pos_d = pos_n;
					if (!hold_v_q) begin
						hold_d   = b;
						hold_v_d = 1'b1;
					end else begin
						hold_v_d   = 1'b0;
						left_d     = left_two;
						emit       = 1'b1;
						res.kind   = KIND_FRAME;
						res.sample = {b, hold_q};
						res.last   = (left_two == 33'd0);
						if (left_two == 33'd0)
							phase_d = PH_STOP;
					end
				end
				PH_STOP: begin
				end
				default: begin
				end
			endcase
			if (emit && phase_e != PH_DATA)
				res.kind = KIND_ERROR;
			if (emit && res.kind == KIND_ERROR)
				phase_d = PH_STOP;
		end
	end

	assign res_valid = emit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_RIFF;
			pos_q    <= '0;
			shift_q  <= '0;
			hcnt_q   <= '0;
			fcnt_q   <= '0;
			left_q   <= '0;
			seen_q   <= 1'b0;
			hold_q   <= '0;
			hold_v_q <= 1'b0;
		end else begin
			phase_q  <= phase_d;
			pos_q    <= pos_d;
			shift_q  <= shift_d;
			hcnt_q   <= hcnt_d;
			fcnt_q   <= fcnt_d;
			left_q   <= left_d;
			seen_q   <= seen_d;
			hold_q   <= hold_d;
			hold_v_q <= hold_v_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_pop && phase_e == PH_FMT)
			fmt_q[fcnt_q] <= b;
	end

endmodule

// ===== src/wpp_out_queue.sv =====
module wpp_out_queue import wpp_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  res_item_t push_item,
	output logic      room,
	input  logic      pop,
	output logic      empty,
	output res_item_t head
);

	res_item_t   mem_q [2];
	logic        wr_ptr_q;
	logic        rd_ptr_q;
	logic [1:0]  count_q;
	logic        do_push;
	logic        do_pop;

	assign room    = (count_q != 2'd2);
	assign empty   = (count_q == 2'd0);
	assign head    = mem_q[rd_ptr_q];
	assign do_push = push && room;
	assign do_pop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			if (do_push && !do_pop)
				count_q <= count_q + 2'd1;
			else if (do_pop && !do_push)
				count_q <= count_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			mem_q[wr_ptr_q] <= push_item;
	end

endmodule

// ===== src/wav_pcm_stream_parser_top.sv =====
// Streaming RIFF/WAVE parser for 16-bit mono PCM. Push one file byte per
// transaction, with file_start high on byte 0 of each file; the block takes
// one byte every cycle while the result queue is being drained. A byte goes
// through a two-entry input queue, the parser step (one byte per cycle while
// the result queue has room), and a two-entry result queue. The parser pops
// a byte and pushes its result into the result queue in the same cycle.
// Each data sample comes out as a frame with the sample on both
// channels and last_frame on the final one; a header or format problem gives
// one error report and the block ignores bytes until the next file_start.
// Write file_length and required_rate (reset 0 and 44100) only while idle.
module wav_pcm_stream_parser_top import wpp_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic [7:0]         byte_value,
	input  logic               file_start,
	output logic               empty,
	input  logic               pop,
	output logic               item_kind,
	output logic signed [15:0] left_sample,
	output logic signed [15:0] right_sample,
	output logic               last_frame,
	output logic [2:0]         error_code,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data
);

	cfg_t      cfg_q;
	in_item_t  in_item;
	in_item_t  head;
	logic      head_valid;
	logic      head_pop;
	logic      out_room;
	logic      res_valid;
	res_item_t res;
	res_item_t out_head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.file_length   <= '0;
			cfg_q.required_rate <= RATE_RESET;
		end else if (cfg_valid) begin
			unique case (cfg_index_t'(cfg_index))
				CFG_FILE_LENGTH:   cfg_q.file_length   <= cfg_data;
				CFG_REQUIRED_RATE: cfg_q.required_rate <= cfg_data[17:0];
				default: begin
				end
			endcase
		end
	end

	assign in_item.byte_value = byte_value;
	assign in_item.file_start = file_start;

	wpp_in_queue u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (in_item),
		.full      (full),
		.pop       (head_pop),
		.valid     (head_valid),
		.head      (head)
	);

	wpp_parser u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.in_valid  (head_valid),
		.in_item   (head),
		.in_pop    (head_pop),
		.out_room  (out_room),
		.res_valid (res_valid),
		.res       (res)
	);

	wpp_out_queue u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (res_valid),
		.push_item (res),
		.room      (out_room),
		.pop       (pop),
		.empty     (empty),
		.head      (out_head)
	);

	assign item_kind    = out_head.kind;
	assign left_sample  = out_head.sample;
	assign right_sample = out_head.sample;
	assign last_frame   = out_head.last;
	assign error_code   = out_head.code;

endmodule

// ===== dv/tb.sv =====
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import wpp_pkg::*;

	localparam int unsigned RANDOM_ITEMS = 250;
	localparam int unsigned DRAIN_CYCLES = 8;
	localparam int unsigned CYCLE_LIMIT  = 500000;
	localparam logic [15:0] EXTREMES [6] = '{16'h0000, 16'h7FFF, 16'h8000, 16'hFFFF,
		16'h0001, 16'hFFFE};

	typedef struct {
		int unsigned junk;
		int unsigned fmt_size;
		int unsigned fmt_count;
		int unsigned data_size;
		int unsigned tail;
		logic [15:0] fmt_code;
		logic [15:0] chans;
		logic [15:0] align;
		logic [15:0] bits;
		logic [31:0] srate;
		logic [31:0] brate;
		bit          data_first;
		bit          has_data;
	} wav_spec_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               push = 1'b0;
	logic               full;
	logic [7:0]         byte_value = 8'd0;
	logic               file_start = 1'b0;
	logic               empty;
	logic               pop = 1'b0;
	logic               item_kind;
	logic signed [15:0] left_sample;
	logic signed [15:0] right_sample;
	logic               last_frame;
	logic [2:0]         error_code;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic               cfg_index = 1'b0;
	logic [31:0]        cfg_data = 32'd0;

	// parser copy
	phase_t      wav_phase;
	logic [31:0] byte_pos;
	logic [63:0] hdr_bits;
	logic [63:0] chunk_rem;
	logic [63:0] fmt_lo;
	logic [63:0] fmt_hi;
	logic        fmt_seen;
	logic        fmt_ok;
	logic [8:0]  sample_low;
	logic        stopped;
	logic [31:0] len_reg = 32'd0;
	logic [17:0] rate_reg = RATE_RESET;

	res_item_t   results_due[$];
	res_item_t   head;
	logic [7:0]  fb[$];
	int unsigned data_at = 0;
	int unsigned live_bytes = 0;
	int unsigned cycles = 0;
	int unsigned rx_hold = 0;
	int          fails = 0;
	bit          idle_on = 1'b1;

	wav_pcm_stream_parser_top dut (.*);

	always #10 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	function automatic void clear_parse();
		wav_phase = PH_RIFF;
		byte_pos = 32'd0;
		hdr_bits = 64'd0;
		chunk_rem = 64'd0;
		fmt_lo = 64'd0;
		fmt_hi = 64'd0;
		fmt_seen = 1'b0;
		fmt_ok = 1'b0;
		sample_low = 9'd0;
		stopped = 1'b0;
	endfunction

	function automatic void raise_error(input err_code_t code);
		res_item_t r;
		stopped = 1'b1;
		r.kind = KIND_ERROR;
		r.sample = 16'sd0;
		r.last = 1'b0;
		r.code = code;
		results_due.push_back(r);
	endfunction

	function automatic void open_chunk_header();
		wav_phase = PH_HDR;
		chunk_rem = 64'd0;
		hdr_bits = 64'd0;
		if ({32'd0, byte_pos} + 64'd8 > {32'd0, len_reg})
			raise_error(ERR_NO_CHUNK);
	endfunction

	function automatic void skip_or_open(input logic [63:0] remaining);
		if (remaining == 64'd0)
			open_chunk_header();
		else begin
			wav_phase = PH_SKIP;
			chunk_rem = remaining;
		end
	endfunction

	task automatic parse_byte(input logic [7:0] b, input logic s);
		logic [31:0] at;
		logic [31:0] tag;
		logic [31:0] raw;
		logic [31:0] sz;
		logic [63:0] span;
		logic [3:0]  idx;
		res_item_t   r;
		if (s)
			clear_parse();
		if (stopped || wav_phase == PH_STOP)
			return;
		live_bytes++;
		at = byte_pos;
		byte_pos = byte_pos + 32'd1;
		case (wav_phase)
			PH_RIFF: begin
				hdr_bits = {hdr_bits[55:0], b};
				if (at == 32'd3 && hdr_bits[31:0] != TAG_RIFF)
					raise_error(ERR_BAD_RIFF);
				else if (at >= RIFF_LEN - 1) begin
					if (hdr_bits[31:0] != TAG_WAVE || len_reg < RIFF_LEN)
						raise_error(ERR_BAD_RIFF);
					else
						open_chunk_header();
				end
			end
			PH_HDR: begin
				hdr_bits = {hdr_bits[55:0], b};
				chunk_rem = chunk_rem + 64'd1;
				if (chunk_rem >= HDR_BYTES) begin
					tag = hdr_bits[63:32];
					raw = hdr_bits[31:0];
					sz = {raw[7:0], raw[15:8], raw[23:16], raw[31:24]};
					span = {32'd0, sz} + {63'd0, sz[0]};
					if ({32'd0, byte_pos} + span > {32'd0, len_reg})
						raise_error(ERR_PAST_END);
					else if (tag == TAG_FMT) begin
						if (sz < FMT_BYTES)
							raise_error(ERR_FMT_SHORT);
						else begin
							wav_phase = PH_FMT;
							chunk_rem = span;
							hdr_bits = 64'd0;
							fmt_lo = 64'd0;
							fmt_hi = 64'd0;
						end
					end else if (tag == TAG_DATA) begin
						if (!fmt_seen)
							raise_error(ERR_DATA_FIRST);
						else begin
							fmt_ok = fmt_lo[15:0] == 16'd1 && fmt_lo[31:16] == 16'd1 &&
								fmt_lo[63:32] == {14'd0, rate_reg} &&
								fmt_hi[63:48] == 16'd16 && fmt_hi[47:32] == 16'd2 &&
								fmt_hi[31:0] == {13'd0, rate_reg, 1'b0};
							if (!fmt_ok)
								raise_error(ERR_UNSUPPORTED);
							else if (sz == 32'd0 || sz[0])
								raise_error(ERR_DATA_SIZE);
							else begin
								wav_phase = PH_DATA;
								chunk_rem = {32'd0, sz};
								sample_low = 9'd0;
							end
						end
					end else
						skip_or_open(span);
				end
			end
			PH_FMT: begin
				idx = hdr_bits[3:0];
				if (idx[3])
					fmt_hi = fmt_hi | ({56'd0, b} << (8 * idx[2:0]));
				else
					fmt_lo = fmt_lo | ({56'd0, b} << (8 * idx[2:0]));
				hdr_bits = hdr_bits + 64'd1;
				if (chunk_rem != 64'd0)
					chunk_rem = chunk_rem - 64'd1;
				if (hdr_bits >= FMT_BYTES) begin
					fmt_seen = 1'b1;
					skip_or_open(chunk_rem);
				end
			end
			PH_SKIP: begin
				if (chunk_rem != 64'd0)
					chunk_rem = chunk_rem - 64'd1;
				if (chunk_rem == 64'd0)
					open_chunk_header();
			end
			PH_DATA: begin
				if (!sample_low[8])
					sample_low = {1'b1, b};
				else begin
					chunk_rem = (chunk_rem >= 64'd2) ? chunk_rem - 64'd2 : 64'd0;
					r.kind = KIND_FRAME;
					r.sample = {b, sample_low[7:0]};
					r.last = (chunk_rem == 64'd0);
					r.code = ERR_BAD_RIFF;	// code field reads zero on a frame
					results_due.push_back(r);
					sample_low = 9'd0;
					if (chunk_rem == 64'd0)
						wav_phase = PH_STOP;
				end
			end
			default: ;
		endcase
	endtask

	// file image builder
	function automatic void put8(input logic [7:0] v);
		fb.push_back(v);
	endfunction

	function automatic void put16(input logic [15:0] v);
		put8(v[7:0]);
		put8(v[15:8]);
	endfunction

	function automatic void put32(input logic [31:0] v);
		put16(v[15:0]);
		put16(v[31:16]);
	endfunction

	function automatic void put_tag(input logic [31:0] t);
		put8(t[31:24]);
		put8(t[23:16]);
		put8(t[15:8]);
		put8(t[7:0]);
	endfunction

	function automatic void put_junk();
		logic [31:0] id;
		int unsigned n;
		id = $urandom();
		if (id == TAG_FMT || id == TAG_DATA)
			id[0] = ~id[0];
		n = $urandom_range(0, 5);
		put_tag(id);
		put32(n);
		repeat (n + n % 2) put8(8'($urandom()));
	endfunction

	function automatic void put_data(input int unsigned n);
		data_at = fb.size();
		put_tag(TAG_DATA);
		put32(n);
		repeat (n + n % 2) put8(8'($urandom()));
	endfunction

	function automatic void build_wav(input wav_spec_t w);
		fb.delete();
		put_tag(TAG_RIFF);
		put32($urandom());
		put_tag(TAG_WAVE);
		repeat (w.junk) put_junk();
		if (w.has_data && w.data_first)
			put_data(w.data_size);
		for (int k = 0; k < int'(w.fmt_count); k++) begin
			put_tag(TAG_FMT);
			put32(w.fmt_size);
			if (k == int'(w.fmt_count) - 1 && w.fmt_size >= 16) begin
				put16(w.fmt_code);
				put16(w.chans);
				put32(w.srate);
				put32(w.brate);
				put16(w.align);
				put16(w.bits);
				repeat (w.fmt_size - 16) put8(8'($urandom()));
			end else
				repeat (w.fmt_size) put8(8'($urandom()));
			if (w.fmt_size % 2 != 0)
				put8(8'($urandom()));
		end
		if (w.has_data && !w.data_first)
			put_data(w.data_size);
		repeat (w.tail) put8(8'($urandom()));
	endfunction

	function automatic wav_spec_t good_spec(input int unsigned data_size);
		wav_spec_t w;
		w.junk = 0;
		w.fmt_size = 16;
		w.fmt_count = 1;
		w.data_size = data_size;
		w.tail = 0;
		w.fmt_code = 16'd1;
		w.chans = 16'd1;
		w.align = 16'd2;
		w.bits = 16'd16;
		w.srate = {14'd0, rate_reg};
		w.brate = {13'd0, rate_reg, 1'b0};
		w.data_first = 1'b0;
		w.has_data = 1'b1;
		return w;
	endfunction

	function automatic wav_spec_t random_spec();
		wav_spec_t w;
		w = good_spec(2 * $urandom_range(1, 12));
		w.junk = $urandom_range(0, 2);
		w.fmt_size = ($urandom_range(0, 3) == 0) ? $urandom_range(17, 21) : 16;
		w.fmt_count = ($urandom_range(0, 9) == 0) ? 2 : 1;
		w.tail = $urandom_range(0, 3);
		return w;
	endfunction

	// driving
	task automatic send_byte(input logic [7:0] b, input logic s);
		@(negedge clk);
		while (idle_on && $urandom_range(0, 99) < 25) begin
			push <= 1'b0;
			@(negedge clk);
		end
		push <= 1'b1;
		byte_value <= b;
		file_start <= s;
		do @(posedge clk); while (full);
		parse_byte(b, s);
	endtask

	task automatic send_range(input int lo, input int hi);
		for (int i = lo; i < hi; i++)
			send_byte(fb[i], i == 0);
	endtask

	task automatic settle();
		@(negedge clk);
		push <= 1'b0;
		while (results_due.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
		settle();
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == CFG_FILE_LENGTH)
			len_reg = val;
		else
			rate_reg = val[17:0];
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic play(input logic [31:0] len);
		write_reg(CFG_FILE_LENGTH, len);
		send_range(0, fb.size());
	endtask

	// result side
	always @(negedge clk) begin
		if (rx_hold != 0) begin
			rx_hold--;
			pop <= 1'b0;
		end else
			pop <= !idle_on || $urandom_range(0, 99) >= 25;
	end

	task automatic report(input string field, input int want, input int got);
		$error("%s: expected %0d, got %0d", field, want, got);
		fails++;
	endtask

	always @(posedge clk) begin
		if (arst_n && pop && !empty) begin
			if (results_due.size() == 0) begin
				$error("unexpected transaction: item_kind %0d left_sample %0d error_code %0d",
					item_kind, left_sample, error_code);
				fails++;
			end else begin
				head = results_due.pop_front();
				if (item_kind !== head.kind)
					report("item_kind", head.kind, item_kind);
				if (left_sample !== head.sample)
					report("left_sample", head.sample, left_sample);
				if (right_sample !== head.sample)
					report("right_sample", head.sample, right_sample);
				if (last_frame !== head.last)
					report("last_frame", head.last, last_frame);
				if (error_code !== head.code)
					report("error_code", head.code, error_code);
			end
		end
	end

	// tests
	task automatic test_reset_values();
		build_wav(good_spec(4));
		send_range(0, fb.size());	// file_length still zero
		play(fb.size());
	endtask

	task automatic test_header_errors();
		build_wav(good_spec(4));
		fb[1] = fb[1] ^ 8'h01;
		play(fb.size());
		build_wav(good_spec(4));
		fb[10] = fb[10] ^ 8'h80;
		play(fb.size());
		build_wav(good_spec(4));
		play(11);
		play(12);
		write_reg(CFG_FILE_LENGTH, 32'd0);
		send_range(0, fb.size());
	endtask

	task automatic test_chunk_errors();
		wav_spec_t w;
		w = good_spec(4);
		build_wav(w);
		play(fb.size() - 1);
		w = good_spec(4);
		w.fmt_size = 14;
		build_wav(w);
		play(fb.size());
		w = good_spec(4);
		w.has_data = 1'b0;
		build_wav(w);
		play(fb.size());
		for (int k = 0; k < 6; k++) begin
			w = good_spec(4);
			case (k)
				0: w.fmt_code = 16'd3;
				1: w.chans = 16'd2;
				2: w.srate = w.srate + 32'd2;
				3: w.brate = w.srate;
				4: w.align = 16'd4;
				default: w.bits = 16'd8;
			endcase
			build_wav(w);
			play(fb.size());
		end
		build_wav(good_spec(0));
		play(fb.size());
		build_wav(good_spec(5));
		play(fb.size());
		w = good_spec(4);
		w.data_first = 1'b1;
		w.tail = 6;
		build_wav(w);
		play(fb.size());
	endtask

	task automatic test_samples();
		wav_spec_t w;
		write_reg(CFG_REQUIRED_RATE, 32'd8000);
		w = good_spec(12);
		w.junk = 2;
		w.fmt_size = 17;
		w.fmt_count = 2;
		w.tail = 5;
		build_wav(w);
		for (int k = 0; k < 6; k++) begin
			fb[data_at + 8 + 2 * k] = EXTREMES[k][7:0];
			fb[data_at + 9 + 2 * k] = EXTREMES[k][15:8];
		end
		play(32'hFFFF_FFFF);
		write_reg(CFG_REQUIRED_RATE, 32'd192000);
		build_wav(good_spec(2));
		play(fb.size());
		// restart in the middle of a data chunk
		build_wav(good_spec(16));
		write_reg(CFG_FILE_LENGTH, fb.size());
		send_range(0, data_at + 11);
		build_wav(good_spec(6));
		play(fb.size());
	endtask

	task automatic test_rate_change();
		write_reg(CFG_REQUIRED_RATE, 32'd48000);
		build_wav(good_spec(6));
		write_reg(CFG_FILE_LENGTH, fb.size());
		send_range(0, data_at);
		write_reg(CFG_REQUIRED_RATE, 32'd22050);
		send_range(data_at, fb.size());
		write_reg(CFG_REQUIRED_RATE, 32'd48000);
		play(fb.size());
	endtask

	task automatic test_backpressure();
		write_reg(CFG_REQUIRED_RATE, 32'd44100);
		build_wav(good_spec(64));
		write_reg(CFG_FILE_LENGTH, fb.size());
		rx_hold = 400;
		send_range(0, fb.size());
		settle();
	endtask

	task automatic test_random();
		wav_spec_t   w;
		int unsigned start;
		int unsigned done;
		int unsigned pick;
		int unsigned n;
		logic [31:0] len;
		start = live_bytes;
		while (live_bytes - start < RANDOM_ITEMS) begin
			done = live_bytes - start;
			idle_on = !(done > RANDOM_ITEMS / 5 && done < RANDOM_ITEMS * 4 / 5);
			if ($urandom_range(0, 7) == 0) begin
				pick = $urandom_range(0, 3);
				write_reg(CFG_REQUIRED_RATE, (pick == 0) ? 32'd8000 :
					(pick == 1) ? 32'd192000 : $urandom_range(8000, 192000));
			end
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				build_wav(random_spec());
				n = $urandom_range(0, 9);
				if (n == 0)
					len = fb.size() + $urandom_range(1, 64);
				else if (n == 1)
					len = $urandom_range(0, fb.size());
				else
					len = fb.size();
				play(len);
			end else if (pick < 80) begin
				w = random_spec();
				n = $urandom_range(0, 7);
				case (n)
					0: w.chans = 16'd2;
					1: w.bits = 16'd8;
					2: w.data_size = w.data_size + 1;
					3: w.data_size = 0;
					4: w.data_first = 1'b1;
					5: w.has_data = 1'b0;
					6: w.fmt_size = $urandom_range(0, 15);
					default: ;
				endcase
				build_wav(w);
				if (n == 7) begin
					n = $urandom_range(0, fb.size() - 1);
					fb[n] = fb[n] ^ (8'd1 << $urandom_range(0, 7));
				end
				play(fb.size());
			end else if (pick < 92) begin
				build_wav(random_spec());
				write_reg(CFG_FILE_LENGTH, fb.size());
				send_range(0, $urandom_range(1, fb.size() - 1));
			end else begin
				write_reg(CFG_FILE_LENGTH, $urandom_range(0, 80));
				n = $urandom_range(1, 40);
				repeat (n) send_byte(8'($urandom()), $urandom_range(0, 7) == 0);
			end
		end
		idle_on = 1'b1;
	endtask

	initial begin
		clear_parse();
		repeat (10) @(negedge clk);
		arst_n <= 1'b1;
		test_reset_values();
		test_header_errors();
		test_chunk_errors();
		test_samples();
		test_rate_change();
		test_backpressure();
		test_random();
		settle();
		repeat (20) @(posedge clk);
		if (fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
